// ===== hdl/dsd_pkg.sv =====
// Shared types, constants and register codes for the depth sort block.
`default_nettype none
package dsd_pkg;

   // Field widths
   localparam int COORD_BITS  = 16;
   localparam int DIST_BITS   = 34;
   localparam int SLOT_BITS   = 6;
   localparam int CSR_IDX_BITS = 2;
   localparam int ABS_KEEP    = 17;
   localparam int MAX_POINTS_DEFAULT = 64;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic                         batch_end;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic [DIST_BITS-1:0] dist_sq;
      logic                 overflow;
      logic                 run_end;
   } rsp_type;

   // One sorted entry held by a cell
   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic [DIST_BITS-1:0] key;
   } entry_type;

   // Broadcast control for the cell row
   typedef struct packed {
      logic      insert;
      logic      shift;
      entry_type fresh;
   } cell_ctl_type;

   // Result of the distance pipeline
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [DIST_BITS-1:0] dist_sq;
   } dist_out_type;

endpackage
`default_nettype wire

// ===== hdl/depth_sort_by_distance_unit.sv =====
// Top level of the depth sort unit: config registers, fill control and the cell row.
//
// Usage:
//   Write center_x/y/z over the csr_ channel (index 0..2, always ready) while idle.
//   Stream points on the req_ channel, one beat per cycle while req_stall is
//   low. Each point passes a three-stage distance pipeline and is then inserted
//   into a row of MAX_POINTS sorter cells, farthest first, ties in arrival order.
//   A beat with batch_end set closes the batch: req_stall rises while that beat
//   is in the pipeline and stays high while results drain. The first result is
//   valid once that beat has left the pipeline and the drain flag is set;
//   results then leave on rsp_ one per cycle, cell 0 first, with run_end on the
//   last. Points load at one per cycle; a new batch waits for the last result
//   to leave. When rsp_stall is high the row holds and the result stays put.
//   Points beyond MAX_POINTS are dropped and every result of that batch shows
//   overflow. Reset clears the centers, the fill count, the drop flag and the
//   pipeline; the cell contents need no clearing.
`default_nettype none
module depth_sort_by_distance_unit #(
   parameter int MAX_POINTS = dsd_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire dsd_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dsd_pkg::rsp_type          rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [dsd_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [dsd_pkg::COORD_BITS-1:0]   csr_data
);

   localparam int FILL_W = $clog2(MAX_POINTS + 1);

   logic signed [dsd_pkg::COORD_BITS-1:0] center_x_ff, center_y_ff, center_z_ff;

   logic              req_beat, rsp_beat;
   logic              end_in_flight;
   dsd_pkg::dist_out_type dist_res;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic              drain_ff, drain_in;
   logic              drop_ff, drop_in;
   logic              room;

   logic [2:0]        last_pipe_ff;

   dsd_pkg::cell_ctl_type ctl;
   dsd_pkg::entry_type    entries [MAX_POINTS];
   logic                  keeps   [MAX_POINTS];

   // Config writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dsd_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            dsd_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            dsd_pkg::CSR_CENTER_Z: center_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Track batch_end beats in the distance pipeline to hold off the next batch
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pipe_ff <= '0;
      end else begin
         last_pipe_ff <= {last_pipe_ff[1:0], req_beat & req_data.batch_end};
      end
   end

   assign end_in_flight = |last_pipe_ff;
   assign req_stall     = drain_ff | end_in_flight;
   assign req_beat      = req_valid & ~req_stall;

   dsd_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_beat),
      .in_data  (req_data),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .out      (dist_res)
   );

   // Fill, drop and drain control
   assign room     = fill_ff < FILL_W'(MAX_POINTS);
   assign rsp_beat = drain_ff & ~rsp_stall;

   always_comb begin
      fill_in  = fill_ff;
      rem_in   = rem_ff;
      drain_in = drain_ff;
      drop_in  = drop_ff;
      if (dist_res.valid) begin
         if (room) begin
            fill_in = fill_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
         if (dist_res.last) begin
            fill_in  = '0;
            drain_in = 1'b1;
            rem_in   = room ? fill_ff + 1'b1 : fill_ff;
         end
      end
      if (rsp_beat) begin
         rem_in = rem_ff - 1'b1;
         if (rem_ff == FILL_W'(1)) begin
            drain_in = 1'b0;
            drop_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rem_ff   <= '0;
         drain_ff <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
         drain_ff <= drain_in;
         drop_ff  <= drop_in;
      end
   end

   // Broadcast to the row
   assign ctl.insert    = dist_res.valid & room;
   assign ctl.shift     = rsp_beat;
   assign ctl.fresh.key = dist_res.dist_sq;
   assign ctl.fresh.slot = dsd_pkg::SLOT_BITS'(fill_ff);

   // Row of sorter cells
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      dsd_cell #(
         .INDEX  (i),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .fill        (fill_ff),
         .left_entry  ((i == 0) ? ctl.fresh : entries[(i == 0) ? 0 : i - 1]),
         .left_keep   ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
         .right_entry (entries[(i == MAX_POINTS - 1) ? i : i + 1]),
         .entry       (entries[i]),
         .keep        (keeps[i])
      );
   end

   // Results leave from the head cell
   assign rsp_valid        = drain_ff;
   assign rsp_data.slot    = entries[0].slot;
   assign rsp_data.dist_sq = entries[0].key;
   assign rsp_data.overflow = drop_ff;
   assign rsp_data.run_end = (rem_ff == FILL_W'(1));

`ifndef SYNTHESIS
   a_no_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while results drain");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.run_end) |=> !rsp_valid)
      else $error("results continue after run_end");

   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (rem_ff != '0))
      else $error("drain with nothing left");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_POINTS))
      else $error("fill count beyond capacity");

   a_no_insert_in_drain: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> !dist_res.valid)
      else $error("point reached the row during drain");
`endif

endmodule
`default_nettype wire

// ===== hdl/dsd_dist.sv =====
// Three-stage pipeline computing the saturated squared distance of one point.
`default_nettype none
module dsd_dist (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire dsd_pkg::req_type     in_data,
   input  wire logic signed [dsd_pkg::COORD_BITS-1:0] center_x,
   input  wire logic signed [dsd_pkg::COORD_BITS-1:0] center_y,
   input  wire logic signed [dsd_pkg::COORD_BITS-1:0] center_z,
   output dsd_pkg::dist_out_type     out
);

   localparam int DW = dsd_pkg::DIST_BITS;
   localparam int AW = dsd_pkg::ABS_KEEP;

   logic signed [dsd_pkg::COORD_BITS-1:0] pos [3];
   logic signed [dsd_pkg::COORD_BITS-1:0] cen [3];
   logic signed [DW-1:0] diff [3];
   logic        [DW-1:0] mag  [3];

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff;
   logic [AW-1:0] s1_abs_ff [3];
   logic          s1_big_ff [3];

   logic          s2_valid_ff;
   logic          s2_last_ff;
   logic [DW-1:0] s2_sq_ff [3];

   logic          s3_valid_ff;
   logic          s3_last_ff;
   logic [DW-1:0] s3_dist_ff;

   logic [DW+1:0] sum_wide;

   assign pos[0] = in_data.pos_x;
   assign pos[1] = in_data.pos_y;
   assign pos[2] = in_data.pos_z;
   assign cen[0] = center_x;
   assign cen[1] = center_y;
   assign cen[2] = center_z;
   assign s1_valid_in = in_valid;

   // Sign-extend, subtract and take the magnitude per axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = DW'(pos[a]) - DW'(cen[a]);
         mag[a]  = diff[a][DW-1] ? DW'(-diff[a]) : DW'(diff[a]);
      end
   end

   // Stage 1: magnitudes and saturation flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_last_ff <= in_data.batch_end;
      for (int a = 0; a < 3; a++) begin
         s1_abs_ff[a] <= mag[a][AW-1:0];
         s1_big_ff[a] <= |mag[a][DW-1:AW];
      end
   end

   // Stage 2: 17x17 square per axis (zero-extended, full product), or DIST_MAX if saturated
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff <= s1_last_ff;
      for (int a = 0; a < 3; a++) begin
         s2_sq_ff[a] <= s1_big_ff[a] ? dsd_pkg::DIST_MAX
                                     : DW'(s1_abs_ff[a]) * DW'(s1_abs_ff[a]);
      end
   end

   // Stage 3: sum and clamp
   assign sum_wide = {2'b00, s2_sq_ff[0]} + {2'b00, s2_sq_ff[1]} + {2'b00, s2_sq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_last_ff <= s2_last_ff;
      s3_dist_ff <= (sum_wide > {2'b00, dsd_pkg::DIST_MAX}) ? dsd_pkg::DIST_MAX
                                                            : sum_wide[DW-1:0];
   end

   assign out.valid   = s3_valid_ff;
   assign out.last    = s3_last_ff;
   assign out.dist_sq = s3_dist_ff;

endmodule
`default_nettype wire

// ===== hdl/dsd_cell.sv =====
// One cell of the insertion sorter row: holds an entry, inserts or shifts.
`default_nettype none
module dsd_cell #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 7
) (
   input  wire logic                 clock,
   input  wire dsd_pkg::cell_ctl_type ctl,
   input  wire logic [FILL_W-1:0]    fill,
   input  wire dsd_pkg::entry_type   left_entry,
   input  wire logic                 left_keep,
   input  wire dsd_pkg::entry_type   right_entry,
   output dsd_pkg::entry_type        entry,
   output logic                      keep
);

   dsd_pkg::entry_type entry_ff, entry_in;

   // Keep the held entry if it is occupied and not nearer than the new point
   assign keep = (fill > FILL_W'(INDEX)) && (entry_ff.key >= ctl.fresh.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!keep) begin
            entry_in = left_keep ? ctl.fresh : left_entry;
         end
      end else if (ctl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire
